// ===== hdl/hkrb_pkg.sv =====
`timescale 1ns / 1ps
// hkrb_pkg: request, command and response types plus the key code map
package hkrb_pkg;

   typedef enum logic [1:0] {
      REQ_PRESS       = 2'd0,
      REQ_RELEASE     = 2'd1,
      REQ_RELEASE_ALL = 2'd2,
      REQ_POLL        = 2'd3
   } req_kind_type;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned VIEW_SLOTS  = 6;

   localparam logic [7:0] SHIFT_FLAG      = 8'h80;
   localparam logic [7:0] MOD_LEFT_SHIFT  = 8'h02;
   localparam logic [7:0] FKEY_HIGH_FIRST = 8'hF0;
   localparam logic [7:0] FKEY_HIGH_LAST  = 8'hFB;
   localparam logic [7:0] FKEY_HIGH_BASE  = 8'h68;
   localparam logic [7:0] FKEY_LOW_FIRST  = 8'hC2;
   localparam logic [7:0] FKEY_LOW_LAST   = 8'hCD;
   localparam logic [7:0] FKEY_LOW_BASE   = 8'h3A;
   localparam logic [4:0] MOD_CODE_PREFIX = 5'b10000;

   typedef struct packed {
      req_kind_type req_type;
      logic [7:0]   key_code;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic       report_valid;
      logic [7:0] modifier_byte;
      logic [7:0] slot0_usage;
      logic [7:0] slot1_usage;
      logic [7:0] slot2_usage;
      logic [7:0] slot3_usage;
      logic [7:0] slot4_usage;
      logic [7:0] slot5_usage;
   } rsp_type;

   typedef struct packed {
      logic       mapped;
      logic [7:0] usage;
      logic [7:0] mods;
   } key_map_type;

   typedef struct packed {
      req_kind_type kind;
      key_map_type  key;
   } cmd_type;

   // us layout, bit 7 set means left shift is needed
   localparam logic [7:0] ASCII_USAGE [128] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h29, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
      8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
      8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
      8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
      8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
      8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
      8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
      8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
      8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
      8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
      8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
      8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
   };

   function automatic key_map_type map_key(input logic [7:0] code);
      key_map_type m;
      logic [7:0]  a;
      m = '0;
      a = ASCII_USAGE[code[6:0]];
      if (code[7:3] == MOD_CODE_PREFIX) begin
         m.mapped = 1'b1;
         m.mods   = 8'd1 << code[2:0];
      end else if (code >= FKEY_HIGH_FIRST && code <= FKEY_HIGH_LAST) begin
         m.mapped = 1'b1;
         m.usage  = FKEY_HIGH_BASE + (code - FKEY_HIGH_FIRST);
      end else if (code >= FKEY_LOW_FIRST && code <= FKEY_LOW_LAST) begin
         m.mapped = 1'b1;
         m.usage  = FKEY_LOW_BASE + (code - FKEY_LOW_FIRST);
      end else begin
         m.mapped = 1'b1;
         case (code)
            8'hB0: m.usage = 8'h28;
            8'hB1: m.usage = 8'h29;
            8'hB2: m.usage = 8'h2a;
            8'hB3: m.usage = 8'h2b;
            8'hC1: m.usage = 8'h39;
            8'hD7: m.usage = 8'h4f;
            8'hD8: m.usage = 8'h50;
            8'hD9: m.usage = 8'h51;
            8'hDA: m.usage = 8'h52;
            8'hD1: m.usage = 8'h49;
            8'hD2: m.usage = 8'h4a;
            8'hD3: m.usage = 8'h4b;
            8'hD4: m.usage = 8'h4c;
            8'hD5: m.usage = 8'h4d;
            8'hD6: m.usage = 8'h4e;
            default: begin
               if (!code[7] && a != 8'h00) begin
                  m.usage = a & ~SHIFT_FLAG;
                  if ((a & SHIFT_FLAG) != 8'h00) begin
                     m.mods = MOD_LEFT_SHIFT;
                  end
               end else begin
                  m.mapped = 1'b0;
               end
            end
         endcase
      end
      return m;
   endfunction

endpackage

// ===== hdl/hkrb_fifo.sv =====
`timescale 1ns / 1ps
// hkrb_fifo: small register queue used for the command queue and the response queue
module hkrb_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== hdl/hkrb_front.sv =====
`timescale 1ns / 1ps
// hkrb_front: request intake, key code mapping and command queue
module hkrb_front
   import hkrb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   input  logic    cmd_pop,
   output logic    cmd_empty,
   output cmd_type cmd_data
);

   cmd_type cmd_in;

   always_comb begin
      cmd_in.kind = req_data.req_type;
      cmd_in.key  = map_key(req_data.key_code);
   end

   hkrb_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (cmd_in),
      .full  (full),
      .pop   (cmd_pop),
      .rdata (cmd_data),
      .empty (cmd_empty)
   );

endmodule

// ===== hdl/hkrb_back.sv =====
`timescale 1ns / 1ps
// hkrb_back: modifier and key slot state, command execution and response queue
module hkrb_back
   import hkrb_pkg::*;
#(
   parameter int unsigned SLOT_COUNT = 6
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   output logic    cmd_pop,
   input  cmd_type cmd_data,
   input  logic    pop,
   output logic    empty,
   output rsp_type rsp_data
);

   logic [7:0]            mods_ff;
   logic [7:0]            mods_in;
   logic [7:0]            slots_ff [SLOT_COUNT];
   logic [7:0]            slots_in [SLOT_COUNT];
   logic                  pending_ff;
   logic                  pending_in;
   logic                  ok;
   logic                  valid;
   logic                  rsp_full;
   logic                  go;
   logic [SLOT_COUNT-1:0] first_hit;
   logic [SLOT_COUNT-1:0] first_free;
   logic [7:0]            view [VIEW_SLOTS];
   rsp_type               rsp_in;

   assign go      = !cmd_empty && !rsp_full;
   assign cmd_pop = go;

   // one-hot first matching slot and first free slot
   always_comb begin
      logic hit_seen;
      logic free_seen;
      hit_seen   = 1'b0;
      free_seen  = 1'b0;
      first_hit  = '0;
      first_free = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (!hit_seen && slots_ff[i] == cmd_data.key.usage) begin
            first_hit[i] = 1'b1;
            hit_seen     = 1'b1;
         end
         if (!free_seen && slots_ff[i] == 8'h00) begin
            first_free[i] = 1'b1;
            free_seen     = 1'b1;
         end
      end
   end

   always_comb begin
      mods_in    = mods_ff;
      slots_in   = slots_ff;
      pending_in = pending_ff;
      ok         = 1'b0;
      valid      = 1'b0;
      case (cmd_data.kind)
         REQ_PRESS: begin
            if (cmd_data.key.mapped) begin
               mods_in = mods_ff | cmd_data.key.mods;
               if (cmd_data.key.usage == 8'h00) begin
                  pending_in = 1'b1;
                  ok         = 1'b1;
               end else if (first_hit != '0) begin
                  ok = 1'b1;
               end else if (first_free != '0) begin
                  for (int i = 0; i < SLOT_COUNT; i++) begin
                     if (first_free[i]) begin
                        slots_in[i] = cmd_data.key.usage;
                     end
                  end
                  pending_in = 1'b1;
                  ok         = 1'b1;
               end
            end
         end
         REQ_RELEASE: begin
            if (cmd_data.key.mapped) begin
               mods_in = mods_ff & ~cmd_data.key.mods;
               if (cmd_data.key.usage == 8'h00) begin
                  pending_in = 1'b1;
                  ok         = 1'b1;
               end else if (first_hit != '0) begin
                  for (int i = 0; i < SLOT_COUNT; i++) begin
                     if (first_hit[i]) begin
                        slots_in[i] = 8'h00;
                     end
                  end
                  pending_in = 1'b1;
                  ok         = 1'b1;
               end
            end
         end
         REQ_RELEASE_ALL: begin
            mods_in    = 8'h00;
            slots_in   = '{default: 8'h00};
            pending_in = 1'b1;
            ok         = 1'b1;
         end
         REQ_POLL: begin
            valid      = pending_ff;
            ok         = pending_ff;
            pending_in = 1'b0;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   for (genvar g = 0; g < VIEW_SLOTS; g++) begin : g_view
      if (g < SLOT_COUNT) begin : g_used
         assign view[g] = slots_in[g];
      end else begin : g_absent
         assign view[g] = 8'h00;
      end
   end

   always_comb begin
      rsp_in.accepted      = ok;
      rsp_in.report_valid  = valid;
      rsp_in.modifier_byte = mods_in;
      rsp_in.slot0_usage   = view[0];
      rsp_in.slot1_usage   = view[1];
      rsp_in.slot2_usage   = view[2];
      rsp_in.slot3_usage   = view[3];
      rsp_in.slot4_usage   = view[4];
      rsp_in.slot5_usage   = view[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mods_ff    <= 8'h00;
         slots_ff   <= '{default: 8'h00};
         pending_ff <= 1'b0;
      end else if (go) begin
         mods_ff    <= mods_in;
         slots_ff   <= slots_in;
         pending_ff <= pending_in;
      end
   end

   hkrb_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (go),
      .wdata (rsp_in),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_data),
      .empty (empty)
   );

endmodule

// ===== hdl/hid_keyboard_report_builder_top.sv =====
`timescale 1ns / 1ps
// hid_keyboard_report_builder_top: hid keyboard report builder, front and back joined
//
//   channel    ports                      transfer when
//   request    push, full, req_data       push && !full
//   response   empty, pop, rsp_data       pop && !empty
//
// one request per cycle sustained while both queues have room; the back stage
// executes one command each cycle while a command waits and the response queue has room
// reset clears the modifier byte, every key slot, the pending flag and both queues
// the front keeps taking requests while its command queue has room; the back stage
// waits whenever the response queue is full
module hid_keyboard_report_builder_top
   import hkrb_pkg::*;
#(
   parameter int unsigned SLOT_COUNT = 6
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic    cmd_pop;
   logic    cmd_empty;
   cmd_type cmd_data;

   hkrb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_pop   (cmd_pop),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_data)
   );

   hkrb_back #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/hid_keyboard_report_builder_top_test.sv =====
`timescale 1ns / 1ps
// hid_keyboard_report_builder_top_test: self-checking bench with its own report predictor
module hid_keyboard_report_builder_top_test;
   import hkrb_pkg::*;

   localparam int KEY_SLOTS    = 6;
   localparam int RESET_CYCLES = 12;
   localparam int ITEM_TARGET  = 425;
   localparam int HOLD_CYCLES  = 80;
   localparam int HOLD_AT      = 200;
   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int SHOWN_ERRORS = 10;

   typedef struct packed {
      logic       known;
      logic [7:0] usage;
      logic [7:0] mods;
   } key_info_type;

   // us layout, bit 7 flags left shift
   localparam logic [7:0] US_LAYOUT [128] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h29, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
      8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
      8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
      8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
      8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
      8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
      8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
      8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
      8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
      8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
      8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
      8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
   };

   localparam logic [7:0] NAV_CODES [15] = '{
      8'hB0, 8'hB1, 8'hB2, 8'hB3, 8'hC1, 8'hD1, 8'hD2, 8'hD3,
      8'hD4, 8'hD5, 8'hD6, 8'hD7, 8'hD8, 8'hD9, 8'hDA
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    pop = 1'b0;
   req_type req_data = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_data;

   req_type pending_requests [$];
   rsp_type expected_reports [$];

   logic [7:0] held_mods;
   logic [7:0] key_slot [KEY_SLOTS];
   logic       report_due;

   int sent_count = 0;
   int hold_cycles = 0;
   bit hold_done = 1'b0;
   int held_off_total = 0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int kind_count [4] = '{0, 0, 0, 0};
   int refused_full = 0;
   int unmapped_count = 0;
   int delivered_count = 0;

   hid_keyboard_report_builder_top #(.SLOT_COUNT(KEY_SLOTS)) u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic key_info_type decode_key(input logic [7:0] code);
      key_info_type k;
      logic [7:0]   t;
      k = '0;
      t = US_LAYOUT[code[6:0]];
      if (code >= 8'h80 && code <= 8'h87) begin
         k.known = 1'b1;
         k.mods  = 8'h01 << (code - 8'h80);
      end else if (code >= 8'hF0 && code <= 8'hFB) begin
         k.known = 1'b1;
         k.usage = 8'h68 + (code - 8'hF0);
      end else if (code >= 8'hC2 && code <= 8'hCD) begin
         k.known = 1'b1;
         k.usage = 8'h3A + (code - 8'hC2);
      end else begin
         k.known = 1'b1;
         case (code)
            8'hB0: k.usage = 8'h28;
            8'hB1: k.usage = 8'h29;
            8'hB2: k.usage = 8'h2a;
            8'hB3: k.usage = 8'h2b;
            8'hC1: k.usage = 8'h39;
            8'hD7: k.usage = 8'h4f;
            8'hD8: k.usage = 8'h50;
            8'hD9: k.usage = 8'h51;
            8'hDA: k.usage = 8'h52;
            8'hD1: k.usage = 8'h49;
            8'hD2: k.usage = 8'h4a;
            8'hD3: k.usage = 8'h4b;
            8'hD4: k.usage = 8'h4c;
            8'hD5: k.usage = 8'h4d;
            8'hD6: k.usage = 8'h4e;
            default: begin
               if (code[7] || t == 8'h00) begin
                  k.known = 1'b0;
               end else begin
                  k.usage = {1'b0, t[6:0]};
                  if (t[7]) begin
                     k.mods = 8'h02;
                  end
               end
            end
         endcase
      end
      return k;
   endfunction

   task automatic build_report(input req_type r, output rsp_type o);
      key_info_type k;
      logic         ok;
      logic         valid;
      bit           found;
      k = decode_key(r.key_code);
      ok = 1'b0;
      valid = 1'b0;
      found = 1'b0;
      kind_count[r.req_type]++;
      case (r.req_type)
         REQ_PRESS: begin
            if (!k.known) begin
               unmapped_count++;
            end else begin
               held_mods = held_mods | k.mods;
               if (k.usage == 8'h00) begin
                  report_due = 1'b1;
                  ok = 1'b1;
               end else begin
                  for (int i = 0; i < KEY_SLOTS; i++) begin
                     if (key_slot[i] == k.usage) begin
                        found = 1'b1;
                     end
                  end
                  if (found) begin
                     ok = 1'b1;
                  end else begin
                     for (int i = 0; i < KEY_SLOTS; i++) begin
                        if (!ok && key_slot[i] == 8'h00) begin
                           key_slot[i] = k.usage;
                           report_due = 1'b1;
                           ok = 1'b1;
                        end
                     end
                     if (!ok) begin
                        refused_full++;
                     end
                  end
               end
            end
         end
         REQ_RELEASE: begin
            if (!k.known) begin
               unmapped_count++;
            end else begin
               held_mods = held_mods & ~k.mods;
               if (k.usage == 8'h00) begin
                  report_due = 1'b1;
                  ok = 1'b1;
               end else begin
                  for (int i = 0; i < KEY_SLOTS; i++) begin
                     if (!ok && key_slot[i] == k.usage) begin
                        key_slot[i] = 8'h00;
                        report_due = 1'b1;
                        ok = 1'b1;
                     end
                  end
               end
            end
         end
         REQ_RELEASE_ALL: begin
            held_mods = 8'h00;
            for (int i = 0; i < KEY_SLOTS; i++) begin
               key_slot[i] = 8'h00;
            end
            report_due = 1'b1;
            ok = 1'b1;
         end
         default: begin
            valid = report_due;
            report_due = 1'b0;
            ok = valid;
            if (valid) begin
               delivered_count++;
            end
         end
      endcase
      o.accepted      = ok;
      o.report_valid  = valid;
      o.modifier_byte = held_mods;
      o.slot0_usage   = key_slot[0];
      o.slot1_usage   = key_slot[1];
      o.slot2_usage   = key_slot[2];
      o.slot3_usage   = key_slot[3];
      o.slot4_usage   = key_slot[4];
      o.slot5_usage   = key_slot[5];
   endtask

   function automatic int sender_idle_pct(input int n);
      case ((n / 50) % 4)
         1: return 56;
         3: return 23;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct(input int n);
      case ((n / 50) % 4)
         2: return 56;
         3: return 23;
         default: return 0;
      endcase
   endfunction

   function automatic void queue_request(input req_kind_type kind, input logic [7:0] code);
      req_type r;
      r.req_type = kind;
      r.key_code = code;
      pending_requests.push_back(r);
   endfunction

   function automatic logic [7:0] pick_key();
      case ($urandom_range(7))
         0, 1: return 8'(8'h61 + $urandom_range(25));
         2: return 8'(8'h20 + $urandom_range(94));
         3: return 8'(8'h80 + $urandom_range(7));
         4: return 8'(8'hF0 + $urandom_range(11));
         5: return 8'(8'hC2 + $urandom_range(11));
         6: return NAV_CODES[$urandom_range(14)];
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // driver: predicts each request as it is transferred
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            build_report(req_data, want);
            expected_reports.push_back(want);
            sent_count <= sent_count + 1;
         end
         if (!push || !full) begin
            if (pending_requests.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct(sent_count)) begin
               push     <= 1'b1;
               req_data <= pending_requests.pop_front();
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the block fills and stalls its input
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles    <= hold_cycles - 1;
         held_off_total <= held_off_total + 1;
      end else if (!hold_done && sent_count >= HOLD_AT) begin
         hold_cycles <= HOLD_CYCLES;
         hold_done   <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_reports.size() == 0) begin
               if (mismatch_count < SHOWN_ERRORS) begin
                  $display("response with nothing expected: %p", rsp_data);
               end
               mismatch_count++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_data.accepted !== want.accepted ||
                   rsp_data.report_valid !== want.report_valid ||
                   rsp_data.modifier_byte !== want.modifier_byte ||
                   rsp_data.slot0_usage !== want.slot0_usage ||
                   rsp_data.slot1_usage !== want.slot1_usage ||
                   rsp_data.slot2_usage !== want.slot2_usage ||
                   rsp_data.slot3_usage !== want.slot3_usage ||
                   rsp_data.slot4_usage !== want.slot4_usage ||
                   rsp_data.slot5_usage !== want.slot5_usage) begin
                  if (mismatch_count < SHOWN_ERRORS) begin
                     $display("mismatch: expected %p", want);
                     $display("          actual   %p", rsp_data);
                  end
                  mismatch_count++;
               end
            end
         end
         pop <= (hold_cycles == 0) && ($urandom_range(99) >= receiver_stall_pct(sent_count));
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("hid_keyboard_report_builder_top verification failed");
         $finish;
      end
   end

   initial begin
      int         n;
      int         j;
      logic [7:0] c;
      logic [7:0] typed [$];
      held_mods  = 8'h00;
      report_due = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         key_slot[i] = 8'h00;
      end

      queue_request(REQ_POLL, 8'hFF);
      queue_request(REQ_PRESS, 8'h00);
      queue_request(REQ_PRESS, 8'h7F);
      queue_request(REQ_PRESS, 8'hFF);
      queue_request(REQ_PRESS, 8'h61);
      queue_request(REQ_PRESS, 8'h41);
      queue_request(REQ_PRESS, 8'h80);
      queue_request(REQ_PRESS, 8'h87);
      queue_request(REQ_PRESS, 8'hF0);
      queue_request(REQ_PRESS, 8'hCD);
      queue_request(REQ_PRESS, 8'hDA);
      queue_request(REQ_PRESS, 8'hB0);
      queue_request(REQ_PRESS, 8'hC2);
      queue_request(REQ_PRESS, 8'h20);
      queue_request(REQ_POLL, 8'h00);
      queue_request(REQ_POLL, 8'h55);
      queue_request(REQ_RELEASE, 8'h41);
      queue_request(REQ_RELEASE, 8'h61);
      queue_request(REQ_RELEASE, 8'hFB);
      queue_request(REQ_RELEASE, 8'h00);
      queue_request(REQ_RELEASE, 8'h80);
      queue_request(REQ_RELEASE_ALL, 8'hAA);
      queue_request(REQ_POLL, 8'h0F);
      queue_request(REQ_PRESS, 8'hFB);
      queue_request(REQ_RELEASE, 8'hFB);

      while (pending_requests.size() < ITEM_TARGET) begin
         case ($urandom_range(9))
            7: queue_request(req_kind_type'($urandom_range(3)), 8'($urandom_range(255)));
            8: queue_request(REQ_RELEASE_ALL, 8'($urandom_range(255)));
            9: queue_request(REQ_POLL, 8'($urandom_range(255)));
            default: begin
               // typing burst: presses, then releases in shuffled order, with random polls between
               typed.delete();
               n = $urandom_range(1, 9);
               for (int i = 0; i < n; i++) begin
                  c = pick_key();
                  typed.push_back(c);
                  queue_request(REQ_PRESS, c);
                  if ($urandom_range(9) < 3) begin
                     queue_request(REQ_POLL, 8'($urandom_range(255)));
                  end
               end
               for (int i = typed.size() - 1; i > 0; i--) begin
                  j = $urandom_range(i);
                  c = typed[i];
                  typed[i] = typed[j];
                  typed[j] = c;
               end
               foreach (typed[i]) begin
                  queue_request(REQ_RELEASE, typed[i]);
                  if ($urandom_range(9) < 3) begin
                     queue_request(REQ_POLL, 8'($urandom_range(255)));
                  end
               end
            end
         endcase
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_requests.size() != 0 || push || expected_reports.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d requests: %0d press, %0d release, %0d release all, %0d poll",
               sent_count, kind_count[REQ_PRESS], kind_count[REQ_RELEASE],
               kind_count[REQ_RELEASE_ALL], kind_count[REQ_POLL]);
      $display("%0d presses refused on full slots, %0d unmapped codes, %0d reports, %0d held off",
               refused_full, unmapped_count, delivered_count, held_off_total);
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("hid_keyboard_report_builder_top verification clean");
      end else begin
         $display("hid_keyboard_report_builder_top verification failed");
      end
      $finish;
   end

endmodule

// ===== hid_keyboard_report_builder_top.f =====
hdl/hkrb_pkg.sv
hdl/hkrb_fifo.sv
hdl/hkrb_front.sv
hdl/hkrb_back.sv
hdl/hid_keyboard_report_builder_top.sv
test/hid_keyboard_report_builder_top_test.sv
